>>> rtl/sfcs_pkg.sv
package sfcs_pkg;

    typedef struct packed {
        logic        start_req;
        logic [1:0]  opcode;
        logic [23:0] address;
        logic [15:0] length;
        logic [7:0]  data_byte;
        logic [7:0]  rx_byte;
    } sfcs_in_t;

    typedef struct packed {
        logic       select_active;
        logic       tx_valid;
        logic [7:0] tx_byte;
        logic       need_data;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic       timed_out;
        logic       idle;
    } sfcs_res_t;

    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_PROG  = 2'd1;
    localparam logic [1:0] OP_ERASE = 2'd2;

    localparam logic [7:0] FL_READ  = 8'h03;
    localparam logic [7:0] FL_PROG  = 8'h02;
    localparam logic [7:0] FL_ERASE = 8'h20;
    localparam logic [7:0] FL_WREN  = 8'h06;
    localparam logic [7:0] FL_WRDI  = 8'h04;
    localparam logic [7:0] FL_RDSR  = 8'h05;
    localparam logic [7:0] FL_DUMMY = 8'hFF;

    localparam int IN_BITS  = 59;
    localparam int IN_BYTES = (IN_BITS + 7) / 8;
    localparam int OUT_BITS = 22;
    localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

>>> rtl/sfcs_core.sv
module sfcs_core #(
    parameter int PAGE_BYTES = 256
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  sfcs_pkg::sfcs_in_t  item,
    input  logic [15:0]      poll_limit,
    output sfcs_pkg::sfcs_res_t res
);
    import sfcs_pkg::*;

    localparam logic [3:0] PH_IDLE = 4'd0;
    localparam logic [3:0] PH_WREN = 4'd1;
    localparam logic [3:0] PH_GAP1 = 4'd2;
    localparam logic [3:0] PH_CMD  = 4'd3;
    localparam logic [3:0] PH_A2   = 4'd4;
    localparam logic [3:0] PH_A1   = 4'd5;
    localparam logic [3:0] PH_A0   = 4'd6;
    localparam logic [3:0] PH_DATA = 4'd7;
    localparam logic [3:0] PH_GAP2 = 4'd8;
    localparam logic [3:0] PH_STAT = 4'd9;
    localparam logic [3:0] PH_POLL = 4'd10;
    localparam logic [3:0] PH_GAP3 = 4'd11;
    localparam logic [3:0] PH_WRDI = 4'd12;

    localparam logic [15:0] PAGE_LIMIT = 16'(PAGE_BYTES);

    logic [3:0]  phase_reg, phase_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [23:0] addr_reg, addr_next;
    logic [15:0] bytes_left_reg, bytes_left_next;
    logic [15:0] polls_left_reg, polls_left_next;
    logic        rx_is_data_reg, rx_is_data_next;
    logic        timeout_seen_reg, timeout_seen_next;

    logic [15:0] bytes_dec;
    logic [15:0] polls_dec;

    assign bytes_dec = bytes_left_reg - 16'd1;
    assign polls_dec = (polls_left_reg != 16'd0) ? polls_left_reg - 16'd1 : 16'd0;

    always_comb
    begin
        phase_next        = phase_reg;
        cmd_next          = cmd_reg;
        addr_next         = addr_reg;
        bytes_left_next   = bytes_left_reg;
        polls_left_next   = polls_left_reg;
        timeout_seen_next = timeout_seen_reg;
        rx_is_data_next   = 1'b0;
        res               = '0;

        if (rx_is_data_reg)
        begin
            res.read_valid = 1'b1;
            res.read_data  = item.rx_byte;
        end

        unique case (phase_reg)
            PH_IDLE:
            begin
                if (item.start_req && (item.opcode == OP_READ || item.opcode == OP_PROG
                                       || item.opcode == OP_ERASE))
                begin
                    cmd_next          = item.opcode;
                    addr_next         = item.address;
                    timeout_seen_next = 1'b0;
                    polls_left_next   = 16'd0;
                    res.select_active = 1'b1;
                    res.tx_valid      = 1'b1;
                    if (item.opcode == OP_READ)
                    begin
                        bytes_left_next = item.length;
                        phase_next      = PH_CMD;
                        res.tx_byte     = FL_READ;
                    end
                    else
                    begin
                        bytes_left_next = (item.opcode == OP_PROG && item.length <= PAGE_LIMIT)
                                          ? item.length : 16'd0;
                        phase_next      = PH_WREN;
                        res.tx_byte     = FL_WREN;
                    end
                end
            end
            PH_WREN:
            begin
                phase_next = PH_GAP1;
            end
            PH_GAP1:
            begin
                phase_next        = PH_CMD;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = (cmd_reg == OP_PROG) ? FL_PROG : FL_ERASE;
            end
            PH_CMD:
            begin
                phase_next        = PH_A2;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = addr_reg[23:16];
            end
            PH_A2:
            begin
                phase_next        = PH_A1;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = addr_reg[15:8];
            end
            PH_A1:
            begin
                phase_next        = PH_A0;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = addr_reg[7:0];
                res.need_data     = (cmd_reg == OP_PROG) && (bytes_left_reg != 16'd0);
            end
            PH_A0, PH_DATA:
            begin
                if (cmd_reg == OP_ERASE)
                begin
                    phase_next = PH_GAP2;
                end
                else if (bytes_left_reg != 16'd0)
                begin
                    bytes_left_next   = bytes_dec;
                    phase_next        = PH_DATA;
                    res.select_active = 1'b1;
                    res.tx_valid      = 1'b1;
                    if (cmd_reg == OP_READ)
                    begin
                        res.tx_byte     = FL_DUMMY;
                        rx_is_data_next = 1'b1;
                    end
                    else
                    begin
                        res.tx_byte   = item.data_byte;
                        res.need_data = (bytes_dec != 16'd0);
                    end
                end
                else if (cmd_reg == OP_READ)
                begin
                    phase_next    = PH_IDLE;
                    res.done_res  = 1'b1;
                    res.timed_out = timeout_seen_reg;
                end
                else
                begin
                    phase_next = PH_GAP2;
                end
            end
            PH_GAP2:
            begin
                phase_next        = PH_STAT;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = FL_RDSR;
            end
            PH_STAT:
            begin
                polls_left_next   = (poll_limit == 16'd0) ? 16'd1 : poll_limit;
                phase_next        = PH_POLL;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = FL_DUMMY;
            end
            PH_POLL:
            begin
                if (!item.rx_byte[0])
                begin
                    phase_next = PH_GAP3;
                end
                else
                begin
                    polls_left_next = polls_dec;
                    if (polls_dec == 16'd0)
                    begin
                        timeout_seen_next = 1'b1;
                        phase_next        = PH_GAP3;
                    end
                    else
                    begin
                        res.select_active = 1'b1;
                        res.tx_valid      = 1'b1;
                        res.tx_byte       = FL_DUMMY;
                    end
                end
            end
            PH_GAP3:
            begin
                phase_next        = PH_WRDI;
                res.select_active = 1'b1;
                res.tx_valid      = 1'b1;
                res.tx_byte       = FL_WRDI;
            end
            PH_WRDI:
            begin
                phase_next    = PH_IDLE;
                res.done_res  = 1'b1;
                res.timed_out = timeout_seen_reg;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        res.idle = (phase_next == PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            cmd_reg          <= OP_READ;
            addr_reg         <= '0;
            bytes_left_reg   <= '0;
            polls_left_reg   <= '0;
            rx_is_data_reg   <= 1'b0;
            timeout_seen_reg <= 1'b0;
        end
        else if (step)
        begin
            phase_reg        <= phase_next;
            cmd_reg          <= cmd_next;
            addr_reg         <= addr_next;
            bytes_left_reg   <= bytes_left_next;
            polls_left_reg   <= polls_left_next;
            rx_is_data_reg   <= rx_is_data_next;
            timeout_seen_reg <= timeout_seen_next;
        end
    end

endmodule

>>> rtl/spi_flash_command_sequencer.sv
// channel   | signals                               | payload
// ----------+---------------------------------------+---------------------------------
// s_axis    | s_axis_tvalid/tready/tdata[63:0]      | one byte slot item with command
// m_axis    | m_axis_tvalid/tready/tdata[23:0]/tlast| next slot result, tlast = done
// cfg       | cfg_valid/cfg_ready/cfg_data[15:0]    | poll_limit, always ready
//
// one item per cycle while m_axis is not stalled, registered in the input register, then the result register
// the sequencer state advances in the single combinational step between those registers
// rst_n clears the handshake valids, the sequencer state and poll_limit (to 65535)
// a stalled m_axis holds the result register and backs up into the input register
module spi_flash_command_sequencer #(
    parameter int PAGE_BYTES = 256
) (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // start_req, opcode[1:0], address[23:0], length[15:0], data_byte[7:0], rx_byte[7:0]
    input  logic [63:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // select_active, tx_valid, tx_byte[7:0], need_data, read_valid, read_data[7:0],
    // timed_out, idle
    output logic [23:0] m_axis_tdata,
    output logic        m_axis_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import sfcs_pkg::*;

    logic        in_valid_reg;
    sfcs_in_t    in_item_reg;
    logic        out_valid_reg;
    sfcs_res_t   out_res_reg;
    logic [15:0] poll_limit_reg;

    logic        out_free;
    logic        step;
    sfcs_in_t    in_item;
    sfcs_res_t   res;

    assign in_item.start_req = s_axis_tdata[0];
    assign in_item.opcode    = s_axis_tdata[2:1];
    assign in_item.address   = s_axis_tdata[26:3];
    assign in_item.length    = s_axis_tdata[42:27];
    assign in_item.data_byte = s_axis_tdata[50:43];
    assign in_item.rx_byte   = s_axis_tdata[58:51];

    assign out_free      = !out_valid_reg || m_axis_tready;
    assign step          = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign cfg_ready     = 1'b1;

    sfcs_core #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (in_item_reg),
        .poll_limit (poll_limit_reg),
        .res        (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            poll_limit_reg <= 16'hFFFF;
        end
        else
        begin
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            if (out_free)
                out_valid_reg <= in_valid_reg;
            if (cfg_valid && cfg_ready)
                poll_limit_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_item_reg <= in_item;
        if (step)
            out_res_reg <= res;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_res_reg.done_res;
    assign m_axis_tdata  = {2'b00,
                            out_res_reg.idle,
                            out_res_reg.timed_out,
                            out_res_reg.read_data,
                            out_res_reg.read_valid,
                            out_res_reg.need_data,
                            out_res_reg.tx_byte,
                            out_res_reg.tx_valid,
                            out_res_reg.select_active};

    // chip select and byte exchange always go together
    a_sel_tx: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (out_res_reg.select_active == out_res_reg.tx_valid))
        else $error("select and tx disagree");

    // a timeout is only flagged on the finishing result
    a_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.timed_out) |-> m_axis_tlast)
        else $error("timeout without done");

    // a data request always rides on a byte exchange
    a_need_tx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && out_res_reg.need_data) |-> out_res_reg.tx_valid)
        else $error("data request without tx");

    // a finished command leaves the block idle and deselected
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tlast) |-> (out_res_reg.idle && !out_res_reg.select_active))
        else $error("done while busy");

endmodule

>>> tb/sfcs_slot_checker.sv
`timescale 1ns / 1ps

module sfcs_slot_checker (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,

    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,
    input  logic        m_axis_tlast,

    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [15:0] cfg_data,

    output int          errors,
    output int          pending
);
    import sfcs_pkg::*;

    typedef enum logic [3:0] {
        SQ_IDLE,
        SQ_WREN,
        SQ_GAP1,
        SQ_CMD,
        SQ_A2,
        SQ_A1,
        SQ_A0,
        SQ_DATA,
        SQ_GAP2,
        SQ_STAT,
        SQ_POLL,
        SQ_GAP3,
        SQ_WRDI
    } seq_phase_t;

    seq_phase_t  seq;
    logic [1:0]  cur_op;
    logic [23:0] cur_addr;
    logic [15:0] left_bytes;
    logic [15:0] left_polls;
    logic [15:0] poll_cap;
    logic        rd_owed;
    logic        tmo_flag;

    sfcs_res_t   announced_slots[$];
    int          err_count;

    function automatic void put_byte(inout sfcs_res_t r, input logic [7:0] b);
        r.select_active = 1'b1;
        r.tx_valid      = 1'b1;
        r.tx_byte       = b;
    endfunction

    function automatic void end_command(inout sfcs_res_t r);
        seq        = SQ_IDLE;
        r.done_res = 1'b1;
        r.timed_out = tmo_flag;
    endfunction

    // one byte slot through the sequencer, returns the announcement of the next slot
    function automatic sfcs_res_t advance_sequencer(input logic [63:0] d);
        sfcs_res_t   r;
        logic        start;
        logic [1:0]  op;
        logic [23:0] addr;
        logic [15:0] len;
        logic [7:0]  dbyte;
        logic [7:0]  rx;
        start = d[0];
        op    = d[2:1];
        addr  = d[26:3];
        len   = d[42:27];
        dbyte = d[50:43];
        rx    = d[58:51];
        r = '0;
        if (rd_owed)
        begin
            r.read_valid = 1'b1;
            r.read_data  = rx;
        end
        rd_owed = 1'b0;

        case (seq)
            SQ_IDLE:
            begin
                if (start && op <= OP_ERASE)
                begin
                    cur_op     = op;
                    cur_addr   = addr;
                    tmo_flag   = 1'b0;
                    left_polls = '0;
                    if (op == OP_READ)
                    begin
                        left_bytes = len;
                        put_byte(r, FL_READ);
                        seq = SQ_CMD;
                    end
                    else
                    begin
                        left_bytes = (op == OP_PROG && len <= 16'd256) ? len : 16'd0;
                        put_byte(r, FL_WREN);
                        seq = SQ_WREN;
                    end
                end
            end
            SQ_WREN:
                seq = SQ_GAP1;
            SQ_GAP1:
            begin
                put_byte(r, (cur_op == OP_PROG) ? FL_PROG : FL_ERASE);
                seq = SQ_CMD;
            end
            SQ_CMD:
            begin
                put_byte(r, cur_addr[23:16]);
                seq = SQ_A2;
            end
            SQ_A2:
            begin
                put_byte(r, cur_addr[15:8]);
                seq = SQ_A1;
            end
            SQ_A1:
            begin
                put_byte(r, cur_addr[7:0]);
                seq = SQ_A0;
                if (cur_op == OP_PROG && left_bytes != 0)
                    r.need_data = 1'b1;
            end
            SQ_A0, SQ_DATA:
            begin
                if (cur_op == OP_ERASE)
                    seq = SQ_GAP2;
                else if (left_bytes != 0)
                begin
                    left_bytes = left_bytes - 16'd1;
                    seq = SQ_DATA;
                    if (cur_op == OP_READ)
                    begin
                        put_byte(r, FL_DUMMY);
                        rd_owed = 1'b1;
                    end
                    else
                    begin
                        put_byte(r, dbyte);
                        if (left_bytes != 0)
                            r.need_data = 1'b1;
                    end
                end
                else if (cur_op == OP_READ)
                    end_command(r);
                else
                    seq = SQ_GAP2;
            end
            SQ_GAP2:
            begin
                put_byte(r, FL_RDSR);
                seq = SQ_STAT;
            end
            SQ_STAT:
            begin
                left_polls = (poll_cap == 0) ? 16'd1 : poll_cap;
                put_byte(r, FL_DUMMY);
                seq = SQ_POLL;
            end
            SQ_POLL:
            begin
                if (!rx[0])
                    seq = SQ_GAP3;
                else
                begin
                    if (left_polls != 0)
                        left_polls = left_polls - 16'd1;
                    if (left_polls == 0)
                    begin
                        tmo_flag = 1'b1;
                        seq = SQ_GAP3;
                    end
                    else
                        put_byte(r, FL_DUMMY);
                end
            end
            SQ_GAP3:
            begin
                put_byte(r, FL_WRDI);
                seq = SQ_WRDI;
            end
            SQ_WRDI:
                end_command(r);
            default:
                seq = SQ_IDLE;
        endcase

        r.idle = (seq == SQ_IDLE);
        return r;
    endfunction

    task automatic check_field(input string what, input logic [7:0] want,
                               input logic [7:0] got);
        if (want != got)
        begin
            err_count++;
            $display("%0t mismatch %s expected %0h actual %0h", $time, what, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sfcs_res_t want;
        if (!rst_n)
        begin
            seq        = SQ_IDLE;
            cur_op     = OP_READ;
            cur_addr   = '0;
            left_bytes = '0;
            left_polls = '0;
            poll_cap   = 16'hFFFF;
            rd_owed    = 1'b0;
            tmo_flag   = 1'b0;
            err_count  = 0;
            announced_slots.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                poll_cap = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                announced_slots.push_back(advance_sequencer(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (announced_slots.size() == 0)
                begin
                    err_count++;
                    $display("%0t unexpected result %h last %b", $time, m_axis_tdata,
                             m_axis_tlast);
                end
                else
                begin
                    want = announced_slots.pop_front();
                    check_field("select_active", 8'(want.select_active), 8'(m_axis_tdata[0]));
                    check_field("tx_valid", 8'(want.tx_valid), 8'(m_axis_tdata[1]));
                    check_field("tx_byte", want.tx_byte, m_axis_tdata[9:2]);
                    check_field("need_data", 8'(want.need_data), 8'(m_axis_tdata[10]));
                    check_field("read_valid", 8'(want.read_valid), 8'(m_axis_tdata[11]));
                    check_field("read_data", want.read_data, m_axis_tdata[19:12]);
                    check_field("done_res", 8'(want.done_res), 8'(m_axis_tlast));
                    check_field("timed_out", 8'(want.timed_out), 8'(m_axis_tdata[20]));
                    check_field("idle", 8'(want.idle), 8'(m_axis_tdata[21]));
                end
            end
            errors  <= err_count;
            pending <= announced_slots.size();
        end
    end

endmodule

>>> tb/tb_spi_flash_command_sequencer.sv
`timescale 1ns / 1ps

module tb_spi_flash_command_sequencer;
    import sfcs_pkg::*;

    localparam logic [1:0] OP_NONE     = 2'd3;
    localparam int         CYCLE_LIMIT = 500000;
    localparam int         ITEM_TARGET = 1800;

    // status bit0 behavior while a command runs
    localparam int ST_READY  = 0;
    localparam int ST_RANDOM = 1;
    localparam int ST_BUSY   = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    // start_req, opcode[1:0], address[23:0], length[15:0], data_byte[7:0], rx_byte[7:0]
    logic [63:0] s_axis_tdata = '0;

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // select_active, tx_valid, tx_byte[7:0], need_data, read_valid, read_data[7:0],
    // timed_out, idle
    logic [23:0] m_axis_tdata;
    logic        m_axis_tlast;

    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    int          errors;
    int          pending;
    int          gap_pct = 15;
    int          stall_pct = 15;
    int          slots_sent = 0;
    int          done_count = 0;
    int          cycles = 0;

    spi_flash_command_sequencer dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    sfcs_slot_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .errors        (errors),
        .pending       (pending)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
        if (m_axis_tvalid && m_axis_tready && m_axis_tlast)
            done_count <= done_count + 1;

    function automatic logic [63:0] pack_slot(input logic start, input logic [1:0] op,
                                              input logic [23:0] addr,
                                              input logic [15:0] len,
                                              input logic [7:0] dbyte,
                                              input logic [7:0] rx);
        return {5'b0, rx, dbyte, len, addr, op, start};
    endfunction

    task automatic drive_slot(input logic [63:0] d);
        while ($urandom_range(99) < gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do
            @(posedge clk);
        while (!s_axis_tready);
        slots_sent++;
    endtask

    task automatic write_poll_limit(input logic [15:0] v);
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // start a command, then feed slots until its done item comes back
    task automatic run_command(input logic [1:0] op, input logic [23:0] addr,
                               input logic [15:0] len, input int status_mode);
        int         base;
        int         k;
        logic       busy_start;
        logic [7:0] rx;
        base = done_count;
        drive_slot(pack_slot(1'b1, op, addr, len, 8'($urandom_range(255)),
                             8'($urandom_range(255))));
        k = 0;
        while (done_count == base)
        begin
            k++;
            // starts in the first slots hit a busy block
            busy_start = (k <= 4) && ($urandom_range(3) == 0);
            rx = 8'($urandom_range(255));
            if (status_mode == ST_READY)
                rx[0] = 1'b0;
            else if (status_mode == ST_BUSY)
                rx[0] = 1'b1;
            drive_slot(pack_slot(busy_start, 2'($urandom_range(3)), 24'($urandom),
                                 16'($urandom), 8'($urandom_range(255)), rx));
        end
    endtask

    task automatic drive_noise(input logic start);
        drive_slot(pack_slot(start, start ? OP_NONE : 2'($urandom_range(3)), 24'($urandom),
                             16'($urandom), 8'($urandom_range(255)),
                             8'($urandom_range(255))));
    endtask

    task automatic run_random_command(input logic [15:0] lim);
        logic [1:0]  op;
        logic [15:0] len;
        int          lp;
        int          mode;
        op = 2'($urandom_range(2));
        lp = $urandom_range(99);
        if (lp < 65)
            len = 16'($urandom_range(6));
        else if (lp < 88)
            len = 16'($urandom_range(7, 40));
        else if (lp < 97 || op != OP_PROG)
            len = 16'($urandom_range(41, 300));
        else
            len = 16'($urandom_range(65535));
        mode = (lim <= 16'd64) ? $urandom_range(2) : $urandom_range(1);
        run_command(op, 24'($urandom), len, mode);
    endtask

    initial
    begin
        logic [15:0] lim;
        int          pick;
        int          drain;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset poll limit
        run_command(OP_READ, 24'h000000, 16'd0, ST_RANDOM);
        run_command(OP_READ, 24'hFFFFFF, 16'd3, ST_RANDOM);
        drive_noise(1'b1);
        run_command(OP_PROG, 24'h000000, 16'd0, ST_READY);
        run_command(OP_PROG, 24'hFFFFFF, 16'd1, ST_RANDOM);
        run_command(OP_ERASE, 24'hFFFFFF, 16'hFFFF, ST_RANDOM);
        run_command(OP_PROG, 24'h5A5A5A, 16'hFFFF, ST_RANDOM);
        run_command(OP_PROG, 24'hA5A5A5, 16'd257, ST_READY);
        drive_noise(1'b0);

        write_poll_limit(16'd1);
        run_command(OP_ERASE, 24'h123456, 16'd0, ST_BUSY);
        run_command(OP_PROG, 24'h00FF00, 16'd2, ST_BUSY);
        run_command(OP_PROG, 24'hFF00FF, 16'd256, ST_READY);

        // zero behaves as a limit of one
        write_poll_limit(16'd0);
        run_command(OP_ERASE, 24'h654321, 16'd0, ST_BUSY);
        run_command(OP_PROG, 24'h0F0F0F, 16'd4, ST_RANDOM);

        write_poll_limit(16'd3);
        run_command(OP_PROG, 24'hF0F0F0, 16'd5, ST_BUSY);

        // full rate stretch at the largest limit
        write_poll_limit(16'hFFFF);
        gap_pct   = 0;
        stall_pct = 0;
        repeat (25) run_random_command(16'hFFFF);
        gap_pct   = 15;
        stall_pct = 15;

        while (slots_sent < ITEM_TARGET)
        begin
            case ($urandom_range(5))
                0:       lim = 16'd1;
                1:       lim = 16'($urandom_range(2, 8));
                2:       lim = 16'($urandom_range(9, 64));
                3:       lim = 16'hFFFF;
                4:       lim = 16'($urandom_range(65535));
                default: lim = 16'd0;
            endcase
            write_poll_limit(lim);
            repeat ($urandom_range(8, 20))
            begin
                if (slots_sent < ITEM_TARGET)
                begin
                    pick = $urandom_range(99);
                    if (pick < 5)
                        drive_noise(1'b1);
                    else if (pick < 10)
                        drive_noise(1'b0);
                    else
                        run_random_command(lim);
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        drain = 0;
        while (pending != 0 && drain < 2000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (8) @(posedge clk);
        if (errors == 0 && pending == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
rtl/sfcs_pkg.sv
rtl/sfcs_core.sv
rtl/spi_flash_command_sequencer.sv
tb/sfcs_slot_checker.sv
tb/tb_spi_flash_command_sequencer.sv
